FILE: src/ahs_pkg.sv
`default_nettype none

package ahs_pkg;

  // Build-time sizes
  localparam int MAX_HARMONIC    = 100;
  localparam int SINE_TABLE_BITS = 10;
  localparam int AMP_BITS        = 16;

  // Port field widths
  localparam int FREQ_W    = 23;
  localparam int CFG_W     = 32;
  localparam int NYQ_W     = 16;
  localparam int GAIN_W    = 16;
  localparam int SAMPLE_W  = 16;
  localparam int PHASE_W   = 32;
  localparam int CFG_IDX_W = 2;

  // Amplitude and sine formats (1/1 needs one bit above AMP_BITS)
  localparam int AMP_W   = AMP_BITS + 1;
  localparam int SIN_W   = 15;
  localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
  localparam int QIDX_W  = SINE_TABLE_BITS - 1;

  // Harmonic counter, table index and cutoff test widths
  localparam int J_W    = $clog2(MAX_HARMONIC + 1);
  localparam int AIDX_W = $clog2(MAX_HARMONIC);
  localparam int TV_W   = FREQ_W + $clog2(12 * MAX_HARMONIC);

  // Shared multiplier
  localparam int MUL_A_W = (AMP_W > FREQ_W) ? AMP_W : FREQ_W;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Accumulator and output scaling
  localparam int TERM_W    = AMP_W + SIN_W;
  localparam int ACC_RAW_W = TERM_W + 1 + $clog2(4 * MAX_HARMONIC);
  localparam int ACC_W     = (ACC_RAW_W > MUL_B_W) ? ACC_RAW_W : MUL_B_W + 1;
  localparam int MAG_HI_W  = ACC_W - MUL_B_W;
  localparam int TOT_W     = ACC_W + GAIN_W;
  localparam int OUT_SHIFT = AMP_BITS + 15;
  localparam int SC_W      = TOT_W - OUT_SHIFT;

  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

  // Register reset values
  localparam logic [CFG_W-1:0]  INV_RATE_RST = 32'd22906492;
  localparam logic [NYQ_W-1:0]  NYQ_RST      = 16'd24000;
  localparam logic [GAIN_W-1:0] GAIN_RST     = 16'd4096;

  // Register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_INV_RATE = 2'd0;
  localparam cfg_idx_t CFG_NYQUIST  = 2'd1;
  localparam cfg_idx_t CFG_GAIN     = 2'd2;

  // Harmonic groups
  typedef logic [1:0] grp_t;
  localparam grp_t GRP_G1 = 2'd0;
  localparam grp_t GRP_G2 = 2'd1;
  localparam grp_t GRP_G3 = 2'd2;
  localparam grp_t GRP_G4 = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_STEP,
    S_PHASE,
    S_GRP,
    S_TERM,
    S_DRAIN,
    S_MAG,
    S_GLO,
    S_GHI,
    S_GSUM
  } state_t;

  typedef logic [AMP_W-1:0] amp_tbl_t [MAX_HARMONIC];
  typedef logic [SIN_W-1:0] qsin_tbl_t [QUARTER + 1];

  // Quotient rounded half up, by shift and subtract
  function automatic longint unsigned round_div(input longint unsigned num,
                                                input longint unsigned den);
    longint unsigned n;
    longint unsigned rem;
    longint unsigned quo;
    n   = num + (den >> 1);
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], n[b]};
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 64'd1;
      end
    end
    return quo;
  endfunction

  // Amplitude table of one group, rounded half up; decays in Q30
  function automatic amp_tbl_t build_amp(input grp_t g);
    amp_tbl_t t;
    longint unsigned one_amp;
    longint unsigned d1;
    longint unsigned p9;
    longint unsigned p95;
    longint unsigned jj;
    longint unsigned a1;
    longint unsigned a2;
    longint unsigned a34;
    one_amp = 64'd1 << AMP_BITS;
    d1      = 64'd1 << 30;
    p9      = d1;
    p95     = d1;
    t[0]    = '0;
    for (int j = 1; j < MAX_HARMONIC; j++) begin
      jj = 64'(j);
      if (j < 10) begin
        a1 = round_div(one_amp, jj);
        a2 = ((j % 5) == 0) ? round_div(one_amp, 2 * jj) : a1;
      end else begin
        a1 = round_div(one_amp * p9, 10 * d1);
        a2 = ((j % 5) == 0) ? round_div(one_amp * p9, 20 * d1) : a1;
        p9 = (p9 * 9 + 5) / 10;
      end
      if (j < 3) begin
        a34 = (one_amp + 3) / 6;
      end else if (j < 20) begin
        a34 = round_div(one_amp, 2 * jj);
      end else begin
        a34 = round_div(one_amp * p95, 40 * d1);
        p95 = (p95 * 19 + 10) / 20;
      end
      case (g) inside
        GRP_G1:  t[j] = AMP_W'(a1);
        GRP_G2:  t[j] = AMP_W'(a2);
        default: t[j] = AMP_W'(a34);
      endcase
    end
    return t;
  endfunction

  // Quarter-wave sine, Q15, from a Q30 Taylor series up to x^13
  function automatic qsin_tbl_t build_qsin();
    qsin_tbl_t t;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint sum;
    longint v;
    for (int q = 0; q <= QUARTER; q++) begin
      x    = (64'(q) * TWO_PI_Q30) >> SINE_TABLE_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      term = ((term * x2) >> 30) / 6;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 20;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 42;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 72;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 110;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 156;
      sum  = sum + longint'(term);
      if (sum < 0) sum = 0;
      v = (sum + 16384) >>> 15;
      if (v > 32767) v = 32767;
      t[q] = SIN_W'(v);
    end
    return t;
  endfunction

  localparam amp_tbl_t  AMP_G1  = build_amp(GRP_G1);
  localparam amp_tbl_t  AMP_G2  = build_amp(GRP_G2);
  localparam amp_tbl_t  AMP_G34 = build_amp(GRP_G3);
  localparam qsin_tbl_t QSIN    = build_qsin();

endpackage

`default_nettype wire

FILE: src/ahs_mul.sv
`default_nettype none

// Shared unsigned multiplier with a registered product
module ahs_mul (
  input  wire logic                         clk,
  input  wire logic [ahs_pkg::MUL_A_W-1:0]  a,
  input  wire logic [ahs_pkg::MUL_B_W-1:0]  b,
  output logic      [ahs_pkg::MUL_P_W-1:0]  prod
);
  import ahs_pkg::*;

  logic [MUL_P_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= MUL_P_W'(a) * MUL_P_W'(b);
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

FILE: src/ahs_sine_rom.sv
`default_nettype none

// Full-wave sine lookup from a quarter-wave table, registered
// magnitude and sign
module ahs_sine_rom (
  input  wire logic                                 clk,
  input  wire logic [ahs_pkg::SINE_TABLE_BITS-1:0]  idx,
  output logic      [ahs_pkg::SIN_W-1:0]            mag,
  output logic                                      neg
);
  import ahs_pkg::*;

  logic [QIDX_W-1:0] off;
  logic [QIDX_W-1:0] q;
  logic [SIN_W-1:0]  mag_r;
  logic              neg_r;

  // Second and fourth quarters run the table backwards
  assign off = {1'b0, idx[SINE_TABLE_BITS-3:0]};
  assign q   = idx[SINE_TABLE_BITS-2] ? QIDX_W'(QUARTER) - off : off;

  always_ff @(posedge clk) begin
    mag_r <= QSIN[q];
    neg_r <= idx[SINE_TABLE_BITS-1];
  end

  assign mag = mag_r;
  assign neg = neg_r;

endmodule

`default_nettype wire

FILE: src/additive_harmonic_synth.sv
`default_nettype none

// Additive harmonic oscillator bank.
// Input channel (in_valid / in_stall / in_freq_q8): one word per sample tick,
// the fundamental in hertz, unsigned Q8. Output channel (out_valid /
// out_stall / out_sample, out_clipped): one word per input word.
// cfg_we / cfg_index / cfg_wdata write inv_rate (0), nyquist_hz (1) and
// output_gain (2); write only while no word is in flight.
// Per word the phase accumulator is advanced, then four harmonic groups are
// summed one term per cycle through a lookup, multiply, accumulate pipeline
// around one shared multiplier; the same multiplier forms the phase step and
// the two partial products of the gain scaling.
// At most 4 * (MAX_HARMONIC - 1) terms, 396 here, are summed per word. A new
// word is taken only once the previous result has been loaded into the
// output register.
// in_stall is high while a word is being worked on. A finished result sits
// in the output register and the next word is accepted meanwhile; if the
// receiver still stalls when the next result is ready, the block waits.
// Reset loads the register defaults and clears the phase and all valids.
module additive_harmonic_synth (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [ahs_pkg::FREQ_W-1:0]      in_freq_q8,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed [ahs_pkg::SAMPLE_W-1:0]  out_sample,
  output logic                                 out_clipped,
  input  wire logic                            cfg_we,
  input  wire logic [ahs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ahs_pkg::CFG_W-1:0]       cfg_wdata
);
  import ahs_pkg::*;

  state_t               state_r, state_nxt;
  logic [CFG_W-1:0]     inv_rate_r;
  logic [NYQ_W-1:0]     nyq_r;
  logic [GAIN_W-1:0]    gain_r;
  logic [FREQ_W-1:0]    freq_r, freq_nxt;
  logic [PHASE_W-1:0]   phase_r, phase_nxt;
  grp_t                 grp_r, grp_nxt;
  logic [J_W-1:0]       j_r, j_nxt;
  logic [PHASE_W-1:0]   ang_r, ang_nxt;
  logic [PHASE_W-1:0]   ang_step_r, ang_step_nxt;
  logic [TV_W-1:0]      tval_r, tval_nxt;
  logic [TV_W-1:0]      tstep_r, tstep_nxt;
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic [ACC_W-1:0]     mag_r, mag_nxt;
  logic                 sign_r, sign_nxt;
  logic [GAIN_W+MUL_B_W-1:0] plo_r, plo_nxt;
  logic                 va_r, vb_r, neg_b_r;
  logic [AMP_W-1:0]     amp_a_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0]  out_sample_r, out_sample_nxt;
  logic                 out_clipped_r, out_clipped_nxt;

  logic                 issue;
  logic                 grp_done;
  logic [TV_W-1:0]      limit;
  logic [PHASE_W-1:0]   grp_ang;
  logic [TV_W-1:0]      grp_tst;
  logic [TV_W-1:0]      freq_ext;
  logic [AIDX_W-1:0]    aidx;
  logic [AMP_W-1:0]     amp_sel;
  logic [SIN_W-1:0]     sin_mag;
  logic                 sin_neg;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [MUL_P_W-1:0]   mul_p;
  logic [ACC_W-1:0]     term;
  logic [TOT_W-1:0]     total;
  logic [SC_W-1:0]      sc;

  // Shared multiplier and sine lookup
  ahs_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_p)
  );

  ahs_sine_rom u_sine (
    .clk (clk),
    .idx (ang_r[PHASE_W-1 -: SINE_TABLE_BITS]),
    .mag (sin_mag),
    .neg (sin_neg)
  );

  // Group constants: angle step M*phase and cutoff step T*freq
  assign freq_ext = TV_W'(freq_r);
  always_comb begin
    case (grp_r) inside
      GRP_G1:  grp_ang = (phase_r << 3) + (phase_r << 1);
      GRP_G2:  grp_ang = (phase_r << 3) + (phase_r << 2);
      GRP_G3:  grp_ang = (phase_r << 2) + phase_r;
      default: grp_ang = phase_r << 2;
    endcase
    case (grp_r) inside
      GRP_G1:  grp_tst = (freq_ext << 3) + (freq_ext << 1);
      default: grp_tst = (freq_ext << 3) + (freq_ext << 2);
    endcase
  end

  // Amplitude lookup for the current harmonic
  assign aidx = j_r[AIDX_W-1:0];
  always_comb begin
    case (grp_r) inside
      GRP_G1:  amp_sel = AMP_G1[aidx];
      GRP_G2:  amp_sel = AMP_G2[aidx];
      default: amp_sel = AMP_G34[aidx];
    endcase
  end

  assign limit    = TV_W'({nyq_r, 8'd0});
  assign grp_done = (j_r == J_W'(MAX_HARMONIC)) || (tval_r > limit);

  // Signed term from the multiplier, and the gain-scaled magnitude
  assign term  = neg_b_r ? ACC_W'(0) - ACC_W'(mul_p[TERM_W-1:0])
                         : ACC_W'(mul_p[TERM_W-1:0]);
  assign total = (TOT_W'(mul_p[GAIN_W+MAG_HI_W-1:0]) << MUL_B_W) + TOT_W'(plo_r);
  assign sc    = total[TOT_W-1:OUT_SHIFT];

  // Sequencer: next state and datapath control
  always_comb begin
    state_nxt       = state_r;
    freq_nxt        = freq_r;
    phase_nxt       = phase_r;
    grp_nxt         = grp_r;
    j_nxt           = j_r;
    ang_nxt         = ang_r;
    ang_step_nxt    = ang_step_r;
    tval_nxt        = tval_r;
    tstep_nxt       = tstep_r;
    acc_nxt         = vb_r ? acc_r + term : acc_r;
    mag_nxt         = mag_r;
    sign_nxt        = sign_r;
    plo_nxt         = plo_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_sample_nxt  = out_sample_r;
    out_clipped_nxt = out_clipped_r;
    issue           = 1'b0;
    mul_a           = MUL_A_W'(amp_a_r);
    mul_b           = MUL_B_W'(sin_mag);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          freq_nxt  = in_freq_q8;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        mul_a     = MUL_A_W'(freq_r);
        mul_b     = inv_rate_r;
        state_nxt = S_PHASE;
      end
      S_PHASE: begin
        phase_nxt = phase_r + mul_p[PHASE_W+15:16];
        grp_nxt   = GRP_G1;
        acc_nxt   = '0;
        state_nxt = S_GRP;
      end
      S_GRP: begin
        ang_step_nxt = grp_ang;
        ang_nxt      = grp_ang;
        tstep_nxt    = grp_tst;
        tval_nxt     = grp_tst;
        j_nxt        = J_W'(1);
        state_nxt    = S_TERM;
      end
      S_TERM: begin
        if (grp_done) begin
          if (grp_r == GRP_G4) begin
            state_nxt = S_DRAIN;
          end else begin
            grp_nxt   = grp_r + 2'd1;
            state_nxt = S_GRP;
          end
        end else begin
          issue    = 1'b1;
          j_nxt    = j_r + J_W'(1);
          ang_nxt  = ang_r + ang_step_r;
          tval_nxt = tval_r + tstep_r;
        end
      end
      S_DRAIN: begin
        if (!va_r && !vb_r) state_nxt = S_MAG;
      end
      S_MAG: begin
        sign_nxt  = acc_r[ACC_W-1];
        mag_nxt   = acc_r[ACC_W-1] ? ACC_W'(0) - acc_r : acc_r;
        state_nxt = S_GLO;
      end
      S_GLO: begin
        mul_a     = MUL_A_W'(gain_r);
        mul_b     = mag_r[MUL_B_W-1:0];
        state_nxt = S_GHI;
      end
      S_GHI: begin
        mul_a     = MUL_A_W'(gain_r);
        mul_b     = MUL_B_W'(mag_r[ACC_W-1:MUL_B_W]);
        plo_nxt   = mul_p[GAIN_W+MUL_B_W-1:0];
        state_nxt = S_GSUM;
      end
      S_GSUM: begin
        // Keep the upper partial product steady while waiting
        mul_a = MUL_A_W'(gain_r);
        mul_b = MUL_B_W'(mag_r[ACC_W-1:MUL_B_W]);
        // Saturate and load the output register once it is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          if (sign_r) begin
            out_clipped_nxt = sc > SC_W'(32768);
            out_sample_nxt  = out_clipped_nxt ? 16'h8000 : 16'd0 - sc[SAMPLE_W-1:0];
          end else begin
            out_clipped_nxt = sc > SC_W'(32767);
            out_sample_nxt  = out_clipped_nxt ? 16'h7fff : sc[SAMPLE_W-1:0];
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= '0;
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      va_r        <= issue;
      vb_r        <= va_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_rate_r <= INV_RATE_RST;
      nyq_r      <= NYQ_RST;
      gain_r     <= GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INV_RATE: inv_rate_r <= cfg_wdata;
        CFG_NYQUIST:  nyq_r      <= cfg_wdata[NYQ_W-1:0];
        CFG_GAIN:     gain_r     <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    freq_r        <= freq_nxt;
    grp_r         <= grp_nxt;
    j_r           <= j_nxt;
    ang_r         <= ang_nxt;
    ang_step_r    <= ang_step_nxt;
    tval_r        <= tval_nxt;
    tstep_r       <= tstep_nxt;
    acc_r         <= acc_nxt;
    mag_r         <= mag_nxt;
    sign_r        <= sign_nxt;
    plo_r         <= plo_nxt;
    amp_a_r       <= amp_sel;
    neg_b_r       <= sin_neg;
    out_sample_r  <= out_sample_nxt;
    out_clipped_r <= out_clipped_nxt;
  end

  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_sample  = out_sample_r;
  assign out_clipped = out_clipped_r;

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == S_STEP)
    else $error("accepted word did not start the sequence");

  a_issue_from_term: assert property (@(posedge clk) disable iff (!rst_n)
    va_r |-> $past(state_r) == S_TERM)
    else $error("term issued outside the term loop");

  a_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MAG |-> !va_r && !vb_r)
    else $error("gain scaling started with terms in flight");

  a_j_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TERM |-> j_r != '0 && j_r <= J_W'(MAX_HARMONIC))
    else $error("harmonic counter out of range");

  a_clip_extreme: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_clipped_r |->
      out_sample_r == 16'h7fff || out_sample_r == 16'h8000)
    else $error("clipped word is not a full-scale value");

endmodule

`default_nettype wire

FILE: dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ahs_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [FREQ_W-1:0]          freq;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clipped;
  } synth_result_t;

  localparam int HALF_PERIOD      = 10;
  localparam int RESET_CYCLES     = 8;
  localparam int SINE_SIZE        = 1 << SINE_TABLE_BITS;
  localparam int RAND_PHASES      = 6;
  localparam int ITEMS_PER_PHASE  = 140;
  localparam int HOLD_AT          = 200;
  localparam int HOLD_CYCLES      = 1500;
  localparam int WATCHDOG_LIMIT   = 20000;
  localparam int DRAIN_CYCLES     = 4 * (MAX_HARMONIC - 1) + 16 + 32;
  localparam cfg_idx_t CFG_UNUSED = 2'd3;

  // DUT inputs start at known values
  logic                       clk         = 1'b0;
  logic                       rst_n       = 1'b0;
  logic                       in_valid    = 1'b0;
  logic [FREQ_W-1:0]          in_freq_q8  = '0;
  logic                       out_stall   = 1'b0;
  logic                       cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index   = '0;
  logic [CFG_W-1:0]           cfg_wdata   = '0;
  logic                       in_stall;
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_clipped;

  // Predictor state and register copies
  logic [PHASE_W-1:0] phase_m   = '0;
  logic [CFG_W-1:0]   inv_rate_m = INV_RATE_RST;
  logic [NYQ_W-1:0]   nyquist_m = NYQ_RST;
  logic [GAIN_W-1:0]  gain_m    = GAIN_RST;

  // Amplitude sets: 0 = group one, 1 = group two, 2 = groups three and four
  int unsigned amp_lut [3][MAX_HARMONIC];
  int          sine_lut [SINE_SIZE];

  logic [FREQ_W-1:0] pending_freqs [$];
  synth_result_t     expected_samples [$];

  int in_wait      = 0;
  int in_calm      = 0;
  int out_wait     = 0;
  int out_calm     = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  int results_seen = 0;
  int mismatches   = 0;
  int quiet_cycles = 0;

  additive_harmonic_synth u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_freq_q8 (in_freq_q8),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample),
    .out_clipped(out_clipped),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  function automatic u64_t rdiv(input u64_t num, input u64_t den);
    return (num + den / 2) / den;
  endfunction

  // Quarter-wave sine in Q15 from a Q30 Taylor series
  function automatic int qwave(input int unsigned q);
    u64_t    x;
    u64_t    x2;
    u64_t    term;
    longint  s;
    longint  v;
    x    = (u64_t'(q) * TWO_PI_Q30) >> SINE_TABLE_BITS;
    x2   = (x * x) >> 30;
    term = x;
    s    = longint'(x);
    for (int k = 1; k <= 6; k++) begin
      term = ((term * x2) >> 30) / u64_t'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) s = s - longint'(term);
      else            s = s + longint'(term);
    end
    if (s < 0) s = 0;
    v = (s + 16384) >>> 15;
    if (v > 32767) v = 32767;
    return int'(v);
  endfunction

  function automatic void build_luts();
    u64_t one;
    u64_t d1;
    u64_t p9;
    u64_t p95;
    u64_t jj;
    u64_t a;
    int   qtr;
    one = u64_t'(1) << AMP_BITS;
    d1  = u64_t'(1) << 30;
    p9  = d1;
    p95 = d1;
    qtr = SINE_SIZE / 4;
    for (int t = 0; t < 3; t++) amp_lut[t][0] = 0;
    for (int j = 1; j < MAX_HARMONIC; j++) begin
      jj = u64_t'(j);
      // 1/j below ten, then a 0.9 decay; every fifth halved in group two
      if (j < 10) begin
        a = rdiv(one, jj);
        amp_lut[0][j] = int'(a);
        amp_lut[1][j] = (j % 5 == 0) ? int'(rdiv(one, 2 * jj)) : int'(a);
      end else begin
        a = rdiv(one * p9, 10 * d1);
        amp_lut[0][j] = int'(a);
        amp_lut[1][j] = (j % 5 == 0) ? int'(rdiv(one * p9, 20 * d1)) : int'(a);
        p9 = rdiv(p9 * 9, 10);
      end
      // half-weight groups: flat 1/6, then 1/(2j), then a 0.95 decay
      if (j < 3) begin
        amp_lut[2][j] = int'(rdiv(one, 6));
      end else if (j < 20) begin
        amp_lut[2][j] = int'(rdiv(one, 2 * jj));
      end else begin
        amp_lut[2][j] = int'(rdiv(one * p95, 40 * d1));
        p95 = rdiv(p95 * 19, 20);
      end
    end
    for (int i = 0; i < SINE_SIZE; i++) begin
      if (i <= qtr)          sine_lut[i] = qwave(i);
      else if (i <= 2 * qtr) sine_lut[i] = qwave(2 * qtr - i);
      else if (i <= 3 * qtr) sine_lut[i] = -qwave(i - 2 * qtr);
      else                   sine_lut[i] = -qwave(SINE_SIZE - i);
    end
  endfunction

  // Advance the phase, sum the harmonic groups, scale and saturate
  function automatic synth_result_t synthesize_sample(input logic [FREQ_W-1:0] freq);
    synth_result_t      res;
    longint             acc;
    u64_t               mag;
    u64_t               limit;
    logic [PHASE_W-1:0] angle;
    int                 mult;
    int                 cut;
    int                 tbl;
    bit                 neg;
    phase_m = phase_m + PHASE_W'((u64_t'(freq) * u64_t'(inv_rate_m)) >> 16);
    limit   = u64_t'(nyquist_m) << 8;
    acc     = 0;
    for (int gi = 0; gi < 4; gi++) begin
      case (grp_t'(gi))
        GRP_G1:  begin mult = 10; cut = 10; tbl = 0; end
        GRP_G2:  begin mult = 12; cut = 12; tbl = 1; end
        GRP_G3:  begin mult = 5;  cut = 12; tbl = 2; end
        default: begin mult = 4;  cut = 12; tbl = 2; end
      endcase
      for (int j = 1; j < MAX_HARMONIC; j++) begin
        if (u64_t'(j) * u64_t'(cut) * u64_t'(freq) > limit) break;
        angle = PHASE_W'(mult * j) * phase_m;
        acc += longint'(amp_lut[tbl][j]) *
               longint'(sine_lut[angle[PHASE_W-1 -: SINE_TABLE_BITS]]);
      end
    end
    neg = acc < 0;
    mag = neg ? u64_t'(-acc) : u64_t'(acc);
    mag = (mag * u64_t'(gain_m)) >> (AMP_BITS + 15);
    res.freq    = freq;
    res.clipped = 1'b0;
    if (neg && mag > 32768) begin
      mag = 32768;
      res.clipped = 1'b1;
    end else if (!neg && mag > 32767) begin
      mag = 32767;
      res.clipped = 1'b1;
    end
    res.sample = neg ? SAMPLE_W'(0 - mag) : SAMPLE_W'(mag);
    return res;
  endfunction

  task automatic note_mismatch(input string msg);
    if (mismatches < 10) $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Register write; 16-bit registers get junk in the unused upper bits
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
    logic [CFG_W-1:0] data;
    data = value;
    if (idx != CFG_INV_RATE) data[CFG_W-1:NYQ_W] = 16'($urandom);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_INV_RATE: inv_rate_m = data;
      CFG_NYQUIST:  nyquist_m  = data[NYQ_W-1:0];
      CFG_GAIN:     gain_m     = data[GAIN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Block is idle once every queued word went in and every result came out
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_freqs.size() != 0 || in_valid || expected_samples.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Input driver: offers queued frequency words, predicts each accepted one
  always @(posedge clk) begin : drv
    logic offering;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      offering = in_valid;
      if (in_valid && !in_stall) begin
        expected_samples.push_back(synthesize_sample(in_freq_q8));
        offering = 1'b0;
        if (in_calm != 0) begin
          in_calm--;
          in_wait = 0;
        end else begin
          in_wait = $urandom_range(0, 10);
          if ($urandom_range(0, 7) == 0) in_calm = 20;
        end
      end
      if (!offering) begin
        if (in_wait != 0) begin
          in_wait--;
        end else if (pending_freqs.size() != 0) begin
          in_freq_q8 <= pending_freqs.pop_front();
          offering = 1'b1;
        end
      end
      in_valid <= offering;
    end
  end

  // Output monitor: checks each result word and drives the stall
  always @(posedge clk) begin : mon
    synth_result_t want;
    logic          stall_now;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_samples.size() == 0) begin
          note_mismatch($sformatf("unexpected word: sample %0d clipped %0b",
                                  out_sample, out_clipped));
        end else begin
          want = expected_samples.pop_front();
          if (out_sample !== want.sample)
            note_mismatch($sformatf("freq %0d: sample expected %0d, got %0d",
                                    want.freq, $signed(want.sample), out_sample));
          if (out_clipped !== want.clipped)
            note_mismatch($sformatf("freq %0d: clipped expected %0b, got %0b",
                                    want.freq, want.clipped, out_clipped));
        end
        if (out_calm != 0) begin
          out_calm--;
          out_wait = 0;
        end else begin
          out_wait = $urandom_range(0, 10);
          if ($urandom_range(0, 7) == 0) out_calm = 20;
        end
      end
      // one long hold-off so the block backs up into its input
      if (hold_left != 0) begin
        hold_left--;
        stall_now = 1'b1;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
        stall_now = 1'b1;
      end else if (out_wait != 0 && (out_valid || $urandom_range(0, 3) == 0)) begin
        out_wait--;
        stall_now = 1'b1;
      end else begin
        stall_now = 1'b0;
      end
      out_stall <= stall_now;
    end
  end

  // Watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin : wdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stim
    logic [CFG_W-1:0]  rate;
    logic [CFG_W-1:0]  nyq;
    logic [CFG_W-1:0]  gain;
    u64_t              f;
    u64_t              lim;
    int unsigned       cut;
    int unsigned       jh;
    int unsigned       sel;
    build_luts();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: zero, cutoff boundaries, top of range and beyond
    pending_freqs.push_back(23'd0);
    pending_freqs.push_back(23'd0);
    pending_freqs.push_back(23'd1);
    pending_freqs.push_back(23'd112640);
    pending_freqs.push_back(23'd614400);
    pending_freqs.push_back(23'd614401);
    pending_freqs.push_back(23'd512000);
    pending_freqs.push_back(23'd512001);
    pending_freqs.push_back(23'd3000000);
    pending_freqs.push_back(23'd6144000);
    pending_freqs.push_back(23'd6144001);
    pending_freqs.push_back(23'h7FFFFF);
    wait_drained();

    // full gain and cutoff, fastest phase: saturation both ways
    write_reg(CFG_INV_RATE, '1);
    write_reg(CFG_NYQUIST, 32'hFFFF);
    write_reg(CFG_GAIN, 32'hFFFF);
    pending_freqs.push_back(23'd256);
    pending_freqs.push_back(23'd7);
    pending_freqs.push_back(23'd1000);
    pending_freqs.push_back(23'd25600);
    pending_freqs.push_back(23'd51200);
    pending_freqs.push_back(23'd100000);
    wait_drained();

    // frozen phase, tiny cutoff: groups end early or sum nothing
    write_reg(CFG_INV_RATE, '0);
    write_reg(CFG_NYQUIST, 32'd1);
    write_reg(CFG_GAIN, GAIN_RST);
    write_reg(CFG_UNUSED, 32'($urandom));
    pending_freqs.push_back(23'd0);
    pending_freqs.push_back(23'd1);
    pending_freqs.push_back(23'd25);
    pending_freqs.push_back(23'd26);
    pending_freqs.push_back(23'h7FFFFF);
    wait_drained();

    // zero gain
    write_reg(CFG_INV_RATE, INV_RATE_RST);
    write_reg(CFG_NYQUIST, NYQ_RST);
    write_reg(CFG_GAIN, '0);
    pending_freqs.push_back(23'd256);
    pending_freqs.push_back(23'd51200);
    wait_drained();

    // random settings per phase, random frequency words within each
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0:       rate = '0;
        1:       rate = '1;
        2:       rate = INV_RATE_RST;
        default: rate = $urandom;
      endcase
      case ($urandom_range(0, 4))
        0:       nyq = 32'd1;
        1:       nyq = 32'hFFFF;
        2:       nyq = NYQ_RST;
        3:       nyq = 32'd22050;
        default: nyq = $urandom_range(1, 65535);
      endcase
      case ($urandom_range(0, 3))
        0:       gain = '0;
        1:       gain = 32'hFFFF;
        2:       gain = GAIN_RST;
        default: gain = $urandom_range(0, 65535);
      endcase
      write_reg(CFG_INV_RATE, rate);
      write_reg(CFG_NYQUIST, nyq);
      write_reg(CFG_GAIN, gain);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
          f = $urandom_range(0, 256000);
        end else if (sel < 60) begin
          f = $urandom_range(0, 6144000);
        end else if (sel < 72) begin
          f = $urandom_range(0, 23'h7FFFFF);
        end else if (sel < 82) begin
          f = $urandom_range(0, 255);
        end else begin
          // right at a group's cutoff for the current limit
          lim = u64_t'(nyquist_m) << 8;
          cut = ($urandom_range(0, 1) != 0) ? 10 : 12;
          jh  = $urandom_range(1, MAX_HARMONIC - 1);
          f   = lim / u64_t'(cut * jh) + u64_t'($urandom_range(0, 2));
          if (f != 0) f = f - 1;
        end
        pending_freqs.push_back(FREQ_W'(f));
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_samples.size() != 0)
      note_mismatch($sformatf("%0d results never came", expected_samples.size()));
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/ahs_pkg.sv
src/ahs_mul.sv
src/ahs_sine_rom.sv
src/additive_harmonic_synth.sv
dv/testbench.sv
